// File: src/i2d_pkg.sv
package i2d_pkg;

   // field widths fixed by the stream format
   localparam int CHAR_BITS = 6;
   localparam int LEN_BITS  = 4;
   localparam int RSP_BITS  = 16;

   // ascii codes, already narrowed to the character field
   localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 6'd48;
   localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 6'd45;

   // bcd digit threshold for the add-3 correction
   localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
   localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

   typedef logic [3:0] bcd_type;

   // control shared by every cell of the digit chain
   typedef struct packed {
      logic clear;
      logic shift_bit;
      logic shift_digit;
   } i2d_ctl_type;

endpackage

// File: src/i2d_cell.sv
module i2d_cell (
   input  logic                clock,
   input  i2d_pkg::i2d_ctl_type ctl,
   input  logic                bit_in,
   input  i2d_pkg::bcd_type    digit_in,
   output logic                bit_out,
   output i2d_pkg::bcd_type    digit_out
);

   i2d_pkg::bcd_type digit_ff;
   i2d_pkg::bcd_type digit_in_next;
   i2d_pkg::bcd_type adj;

   // add-3 correction so the following doubling stays in bcd
   assign adj = (digit_ff >= i2d_pkg::BCD_ADJ_MIN) ? (digit_ff + i2d_pkg::BCD_ADJ_ADD)
                                                    : digit_ff;

   // carry into the next more significant digit
   assign bit_out   = adj[3];
   assign digit_out = digit_ff;

   // next digit value
   always_comb begin
      if (ctl.clear) begin
         digit_in_next = '0;
      end else if (ctl.shift_bit) begin
         digit_in_next = {adj[2:0], bit_in};
      end else if (ctl.shift_digit) begin
         digit_in_next = digit_in;
      end else begin
         digit_in_next = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_next;
   end

endmodule

// File: src/i2d_chain.sv
module i2d_chain #(
   parameter int DIGITS = 10
) (
   input  logic                 clock,
   input  i2d_pkg::i2d_ctl_type ctl,
   input  logic                 bit_in,
   output i2d_pkg::bcd_type     top_digit
);

   // link i feeds cell i; cell 0 is the least significant digit
   logic             bit_link   [DIGITS+1];
   i2d_pkg::bcd_type digit_link [DIGITS+1];

   assign bit_link[0]   = bit_in;
   assign digit_link[0] = '0;

   // row of bcd cells, each passing its carry and digit upward
   for (genvar i = 0; i < DIGITS; i++) begin : g_cell
      i2d_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .bit_in    (bit_link[i]),
         .digit_in  (digit_link[i]),
         .bit_out   (bit_link[i+1]),
         .digit_out (digit_link[i+1])
      );
   end

   assign top_digit = digit_link[DIGITS];

endmodule

// File: src/integer_to_decimal_ascii.sv
// Formats one WORD_BITS-bit word per transaction as decimal ASCII text, most
// significant character first, no leading zeros, with a leading '-' for a
// negative word when req_tuser is 0 (two's complement) and no sign when it is
// 1 (unsigned). Each result transaction carries one character, tlast on the
// final one, and the total text length. A number is loaded, its magnitude is
// shifted bit by bit through the row of BCD digit cells, leading zero digits
// are skipped one at a time, and then one character is sent per cycle while
// the receiver does not apply back pressure. A new number is accepted once
// the previous one's last character sits in the output register.
module integer_to_decimal_ascii #(
   parameter int WORD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [((WORD_BITS+7)/8)*8-1:0] req_tdata,  // value
   input  logic                  req_tuser,           // action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [i2d_pkg::RSP_BITS-1:0] rsp_tdata,    // character, text_length
   output logic                  rsp_tlast
);

   localparam int DIGITS   = (WORD_BITS * 30103) / 100000 + 1;
   localparam int CNT_BITS = $clog2(WORD_BITS + 1);
   localparam int DIG_BITS = $clog2(DIGITS + 1);

   typedef enum logic [1:0] {
      IDLE,
      CONVERT,
      ALIGN,
      EMIT
   } state_type;

   state_type                     state_ff;
   logic [WORD_BITS-1:0]          mag_ff;
   logic [CNT_BITS-1:0]           bitcnt_ff;
   logic                          neg_ff;
   logic                          sign_pend_ff;
   logic [DIG_BITS-1:0]           remain_ff;
   logic [i2d_pkg::LEN_BITS-1:0]  len_ff;
   logic                          rsp_tvalid_ff;
   logic                          rsp_tlast_ff;
   logic [i2d_pkg::CHAR_BITS-1:0] rsp_char_ff;
   logic [i2d_pkg::LEN_BITS-1:0]  rsp_len_ff;

   logic                          req_accept;
   logic [WORD_BITS-1:0]          value;
   logic                          value_neg;
   logic [WORD_BITS-1:0]          mag_in;
   logic                          emit_load;
   logic                          skip_zero;
   logic [DIG_BITS:0]             len_sum;
   i2d_pkg::i2d_ctl_type          ctl;
   i2d_pkg::bcd_type              top_digit;

   // input transaction and magnitude
   assign req_tready = (state_ff == IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign value      = req_tdata[WORD_BITS-1:0];
   assign value_neg  = !req_tuser && value[WORD_BITS-1];
   assign mag_in     = value_neg ? (~value + WORD_BITS'(1)) : value;

   // output slot free or being drained this cycle
   assign emit_load = (state_ff == EMIT) && (!rsp_tvalid_ff || rsp_tready);
   assign skip_zero = (top_digit == '0) && (remain_ff > DIG_BITS'(1));
   assign len_sum   = {1'b0, remain_ff} + {{DIG_BITS{1'b0}}, neg_ff};

   // digit chain control
   always_comb begin
      ctl.clear       = req_accept;
      ctl.shift_bit   = (state_ff == CONVERT);
      ctl.shift_digit = ((state_ff == ALIGN) && skip_zero) ||
                        (emit_load && !sign_pend_ff);
   end

   i2d_chain #(
      .DIGITS (DIGITS)
   ) u_chain (
      .clock     (clock),
      .ctl       (ctl),
      .bit_in    (mag_ff[WORD_BITS-1]),
      .top_digit (top_digit)
   );

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         sign_pend_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (req_accept) begin
                  mag_ff       <= mag_in;
                  neg_ff       <= value_neg;
                  sign_pend_ff <= value_neg;
                  bitcnt_ff    <= CNT_BITS'(WORD_BITS);
                  state_ff     <= CONVERT;
               end
            end
            CONVERT: begin
               mag_ff    <= {mag_ff[WORD_BITS-2:0], 1'b0};
               bitcnt_ff <= bitcnt_ff - CNT_BITS'(1);
               if (bitcnt_ff == CNT_BITS'(1)) begin
                  remain_ff <= DIG_BITS'(DIGITS);
                  state_ff  <= ALIGN;
               end
            end
            ALIGN: begin
               if (skip_zero) begin
                  remain_ff <= remain_ff - DIG_BITS'(1);
               end else begin
                  len_ff   <= i2d_pkg::LEN_BITS'(len_sum);
                  state_ff <= EMIT;
               end
            end
            EMIT: begin
               if (emit_load) begin
                  rsp_len_ff <= len_ff;
                  if (sign_pend_ff) begin
                     rsp_char_ff  <= i2d_pkg::ASCII_MINUS;
                     rsp_tlast_ff <= 1'b0;
                     sign_pend_ff <= 1'b0;
                  end else begin
                     rsp_char_ff  <= i2d_pkg::ASCII_ZERO + {2'b00, top_digit};
                     rsp_tlast_ff <= (remain_ff == DIG_BITS'(1));
                     remain_ff    <= remain_ff - DIG_BITS'(1);
                     if (remain_ff == DIG_BITS'(1)) begin
                        state_ff <= IDLE;
                     end
                  end
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase

         if (emit_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tdata  = {{(i2d_pkg::RSP_BITS - i2d_pkg::CHAR_BITS - i2d_pkg::LEN_BITS){1'b0}},
                        rsp_len_ff, rsp_char_ff};

`ifndef SYNTHESIS
   // digits still owed whenever characters are being sent
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == EMIT) |-> (remain_ff != '0))
      else $error("emit phase with no digits left");

   // the sign never closes a number
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && (rsp_char_ff == i2d_pkg::ASCII_MINUS)) |-> !rsp_tlast_ff)
      else $error("sign sent as the last character");

   // every accepted word starts a full-length bit pass
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> ((state_ff == CONVERT) && (bitcnt_ff == CNT_BITS'(WORD_BITS))))
      else $error("conversion did not start after accept");
`endif

endmodule

// File: bench/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // action codes carried on req_tuser
   localparam logic ACTION_SIGNED   = 1'b0;
   localparam logic ACTION_UNSIGNED = 1'b1;

   // number of random numbers per idling phase
   localparam int RANDOM_PER_PHASE = 84;

   // one expected character transaction
   typedef struct {
      logic [i2d_pkg::CHAR_BITS-1:0] character;
      logic                          last;
      logic [i2d_pkg::LEN_BITS-1:0]  text_length;
   } ascii_char_type;

   // predicts the decimal text of each accepted number and checks it
   class digit_scoreboard;
      ascii_char_type expected_chars[$];
      int             errors = 0;

      function void note_number(input logic [31:0] value, input logic action);
         logic [32:0]          magnitude;
         logic                 negative;
         logic [3:0]           digit_buf[10];
         int                   ndig;
         int                   total;
         ascii_char_type       c;

         negative  = (action == ACTION_SIGNED) && value[31];
         // wide magnitude so the most negative word stays exact
         magnitude = negative ? (33'h1_0000_0000 - {1'b0, value}) : {1'b0, value};
         ndig = 0;
         do begin
            digit_buf[ndig] = 4'(magnitude % 10);
            magnitude = magnitude / 10;
            ndig++;
         end while (magnitude != 0);
         total = ndig + (negative ? 1 : 0);

         // sign first, then digits from the most significant one
         if (negative) begin
            c.character   = i2d_pkg::ASCII_MINUS;
            c.last        = 1'b0;
            c.text_length = i2d_pkg::LEN_BITS'(total);
            expected_chars.push_back(c);
         end
         for (int i = ndig - 1; i >= 0; i--) begin
            c.character   = i2d_pkg::ASCII_ZERO + i2d_pkg::CHAR_BITS'(digit_buf[i]);
            c.last        = (i == 0);
            c.text_length = i2d_pkg::LEN_BITS'(total);
            expected_chars.push_back(c);
         end
      endfunction

      function void check_char(input logic [i2d_pkg::RSP_BITS-1:0] data,
                               input logic last);
         ascii_char_type                want;
         logic [i2d_pkg::CHAR_BITS-1:0] got_char;
         logic [i2d_pkg::LEN_BITS-1:0]  got_len;

         got_char = data[i2d_pkg::CHAR_BITS-1:0];
         got_len  = data[i2d_pkg::CHAR_BITS +: i2d_pkg::LEN_BITS];
         if (expected_chars.size() == 0) begin
            $error("unexpected character transaction: character %0d, text_length %0d",
                   got_char, got_len);
            errors++;
         end else begin
            want = expected_chars.pop_front();
            if (got_char !== want.character) begin
               $error("character: expected %0d, actual %0d", want.character, got_char);
               errors++;
            end
            if (last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, last);
               errors++;
            end
            if (got_len !== want.text_length) begin
               $error("text_length: expected %0d, actual %0d", want.text_length, got_len);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [31:0]                  req_tdata = '0;   // value
   logic                         req_tuser = 1'b0; // action
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [i2d_pkg::RSP_BITS-1:0] rsp_tdata;        // character, text_length
   logic                         rsp_tlast;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   digit_scoreboard sb = new();

   integer_to_decimal_ascii #(.WORD_BITS(32)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // result side: check accepted characters, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_char(rsp_tdata, rsp_tlast);
      end
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // offer one number, wait for its handshake, then note it
   task automatic send_number(input logic [31:0] value, input logic action);
      int gap;

      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= action;
      do @(posedge clock); while (!req_tready);
      sb.note_number(value, action);
   endtask

   // random word: full range, short widths, powers of ten, negated short widths
   function automatic logic [31:0] pick_value();
      logic [31:0] p;
      int          k;

      case ($urandom_range(0, 3))
         0: pick_value = $urandom;
         1: pick_value = $urandom >> $urandom_range(0, 31);
         2: begin
            k = $urandom_range(0, 9);
            p = 1;
            repeat (k) p = p * 10;
            pick_value = p + $urandom_range(0, 2) - 1;
         end
         default: pick_value = -($urandom >> $urandom_range(0, 31));
      endcase
   endfunction

   // run limit
   initial begin
      #5ms;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, both actions, sign and width boundaries
      send_idle_pct  = 10;
      recv_stall_pct = 58;
      send_number(32'd0, ACTION_SIGNED);
      send_number(32'd0, ACTION_UNSIGNED);
      send_number(32'd1, ACTION_SIGNED);
      send_number(32'd9, ACTION_UNSIGNED);
      send_number(32'd10, ACTION_SIGNED);
      send_number(32'd99, ACTION_SIGNED);
      send_number(32'd100, ACTION_UNSIGNED);
      send_number(32'd999999999, ACTION_SIGNED);
      send_number(32'd1000000000, ACTION_SIGNED);
      send_number(32'h7FFF_FFFF, ACTION_SIGNED);
      send_number(32'h7FFF_FFFF, ACTION_UNSIGNED);
      send_number(32'h8000_0000, ACTION_SIGNED);
      send_number(32'h8000_0000, ACTION_UNSIGNED);
      send_number(32'h8000_0001, ACTION_SIGNED);
      send_number(32'hFFFF_FFFF, ACTION_SIGNED);
      send_number(32'hFFFF_FFFF, ACTION_UNSIGNED);
      send_number(32'hFFFF_FFF6, ACTION_SIGNED);
      send_number(32'hFFFF_FFF7, ACTION_SIGNED);
      send_number(32'h5555_5555, ACTION_SIGNED);
      send_number(32'hAAAA_AAAA, ACTION_SIGNED);
      send_number(32'hAAAA_AAAA, ACTION_UNSIGNED);

      // random numbers under three idling patterns
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 10;
               recv_stall_pct = 58;
            end
            1: begin
               send_idle_pct  = 58;
               recv_stall_pct = 10;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         repeat (RANDOM_PER_PHASE) begin
            send_number(pick_value(), ($urandom_range(0, 1) == 1) ? ACTION_UNSIGNED
                                                                   : ACTION_SIGNED);
         end
      end
      req_tvalid <= 1'b0;

      // drain, then watch for stray characters
      while (sb.pending() != 0) @(posedge clock);
      repeat (64) @(posedge clock);

      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
src/i2d_pkg.sv
src/i2d_cell.sv
src/i2d_chain.sv
src/integer_to_decimal_ascii.sv
bench/tb.sv
